@@ rtl/tpct_pkg.sv @@
// Shared constants and types for the triangle pixel coverage test.
package tpct_pkg;

	localparam int SCREEN_SIZE   = 1024;
	localparam int FRACTION_BITS = 4;

	localparam int VTX_W  = 16;	// vertex coordinate width
	localparam int PIX_W  = 10;	// pixel coordinate width
	localparam int COL_W  = 8;	// colour component width
	localparam int OFF_W  = 13;	// offscreen point coordinate width
	localparam int COEF_W = VTX_W + 1;	// edge coefficient (vertex difference)
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_OFF_X = 2'd0;
	localparam logic [1:0] REG_OFF_Y = 2'd1;
	localparam logic [1:0] REG_BAK_X = 2'd2;
	localparam logic [1:0] REG_BAK_Y = 2'd3;

	localparam logic signed [OFF_W-1:0] OFF_X_RST = -13'sd1;
	localparam logic signed [OFF_W-1:0] OFF_Y_RST = -13'sd1;
	localparam logic signed [OFF_W-1:0] BAK_X_RST = -13'sd2;
	localparam logic signed [OFF_W-1:0] BAK_Y_RST = -13'sd1;

	// sign of an edge value; both clear means zero
	typedef struct packed {
		logic pos;
		logic neg;
	} sign_t;

endpackage

@@ rtl/tpct_edge.sv @@
// Pipelined edge function sign: (ay-by)*(px-ax) + (bx-ax)*(py-ay), three stages.
module tpct_edge #(
	parameter int PW = 17
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [tpct_pkg::VTX_W-1:0]     ax,
	input  logic signed [tpct_pkg::VTX_W-1:0]     ay,
	input  logic signed [tpct_pkg::VTX_W-1:0]     bx,
	input  logic signed [tpct_pkg::VTX_W-1:0]     by,
	input  logic signed [PW-1:0]                  px,
	input  logic signed [PW-1:0]                  py,
	output tpct_pkg::sign_t                       sgn
);

	localparam int CW  = tpct_pkg::COEF_W;
	localparam int DW  = PW + 1;
	localparam int PRW = CW + DW;
	localparam int SW  = PRW + 1;

	logic signed [CW-1:0]  dy_s1, dx_s1;
	logic signed [DW-1:0]  qx_s1, qy_s1;
	logic signed [PRW-1:0] mx_s2, my_s2;
	logic signed [SW-1:0]  sum;
	tpct_pkg::sign_t       sgn_s3;

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (en) begin
			dy_s1 <= CW'(ay) - CW'(by);
			dx_s1 <= CW'(bx) - CW'(ax);
			qx_s1 <= DW'(px) - DW'(ax);
			qy_s1 <= DW'(py) - DW'(ay);
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= PRW'(dy_s1) * PRW'(qx_s1);
			my_s2 <= PRW'(dx_s1) * PRW'(qy_s1);
		end
	end

	assign sum = SW'(mx_s2) + SW'(my_s2);

	// stage 3: sign of the sum
	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3.neg <= sum[SW-1];
			sgn_s3.pos <= !sum[SW-1] && (sum != '0);
		end
	end

	assign sgn = sgn_s3;

endmodule

@@ rtl/triangle_pixel_coverage_test.sv @@
// Top level of the triangle pixel coverage test pipeline.
//
// Use: one item per cycle on the input channel (valid/stall) carries a
// triangle (three corners, signed fixed point with FRACTION_BITS fraction
// bits), an integer pixel position and a colour. When the pixel is on screen,
// inside the half-open bounding box and covered by the triangle, one item
// with the pixel and colour leaves on the output channel (out_valid /
// out_stall); otherwise the item is dropped and nothing comes out.
// Pixels exactly on an edge are resolved with the main offscreen point, then
// the backup point (APB registers 0..3, 13-bit signed pixel units).
// Throughput: one item per clock while the output is not stalled. A drawn
// pixel passes stages s1..s3 (vertex differences, multipliers, sum/sign),
// then the decision into the output register.
// Reset: the pipeline empties and the offscreen registers go to their
// defaults (-1,-1) and (-2,-1).
// Stall: the whole pipeline holds while out_valid is high and out_stall is
// high; stall goes high in those cycles only, so nothing is lost or repeated.
module triangle_pixel_coverage_test #(
	parameter int FRACTION_BITS = tpct_pkg::FRACTION_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   valid,
	output logic                                   stall,
	input  logic signed [tpct_pkg::VTX_W-1:0]      vertex0_x,
	input  logic signed [tpct_pkg::VTX_W-1:0]      vertex0_y,
	input  logic signed [tpct_pkg::VTX_W-1:0]      vertex1_x,
	input  logic signed [tpct_pkg::VTX_W-1:0]      vertex1_y,
	input  logic signed [tpct_pkg::VTX_W-1:0]      vertex2_x,
	input  logic signed [tpct_pkg::VTX_W-1:0]      vertex2_y,
	input  logic        [tpct_pkg::PIX_W-1:0]      pixel_x,
	input  logic        [tpct_pkg::PIX_W-1:0]      pixel_y,
	input  logic        [tpct_pkg::COL_W-1:0]      red,
	input  logic        [tpct_pkg::COL_W-1:0]      green,
	input  logic        [tpct_pkg::COL_W-1:0]      blue,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [tpct_pkg::PIX_W-1:0]      out_x,
	output logic        [tpct_pkg::PIX_W-1:0]      out_y,
	output logic        [tpct_pkg::COL_W-1:0]      out_red,
	output logic        [tpct_pkg::COL_W-1:0]      out_green,
	output logic        [tpct_pkg::COL_W-1:0]      out_blue,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [tpct_pkg::ADDR_W-1:0]     paddr,
	input  logic        [tpct_pkg::DATA_W-1:0]     pwdata,
	output logic        [tpct_pkg::DATA_W-1:0]     prdata,
	output logic                                   pready
);

	localparam int OW = tpct_pkg::OFF_W;
	localparam int VW = tpct_pkg::VTX_W;
	localparam int XW = tpct_pkg::PIX_W;
	localparam int CLW = tpct_pkg::COL_W;
	// scaled point width: offscreen points need OFF_W+FRACTION_BITS, vertices VTX_W
	localparam int PW = (OW + FRACTION_BITS > VW) ? OW + FRACTION_BITS : VW;

	// ---------------- configuration registers ----------------
	logic signed [OW-1:0] off_x_q, off_y_q, bak_x_q, bak_y_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= tpct_pkg::OFF_X_RST;
			off_y_q <= tpct_pkg::OFF_Y_RST;
			bak_x_q <= tpct_pkg::BAK_X_RST;
			bak_y_q <= tpct_pkg::BAK_Y_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tpct_pkg::REG_OFF_X: off_x_q <= pwdata[OW-1:0];
				tpct_pkg::REG_OFF_Y: off_y_q <= pwdata[OW-1:0];
				tpct_pkg::REG_BAK_X: bak_x_q <= pwdata[OW-1:0];
				tpct_pkg::REG_BAK_Y: bak_y_q <= pwdata[OW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tpct_pkg::REG_OFF_X: prdata = tpct_pkg::DATA_W'(off_x_q);
			tpct_pkg::REG_OFF_Y: prdata = tpct_pkg::DATA_W'(off_y_q);
			tpct_pkg::REG_BAK_X: prdata = tpct_pkg::DATA_W'(bak_x_q);
			tpct_pkg::REG_BAK_Y: prdata = tpct_pkg::DATA_W'(bak_y_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// Whole pipeline moves together; it holds only while the output is full and stalled.
	logic advance;
	logic v_s1, v_s2, v_s3;
	logic out_valid_q;

	assign advance = !out_valid_q || !out_stall;
	assign stall   = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- stage 0: scaling, screen and box checks ----------------
	logic signed [VW-1:0] vx [3];
	logic signed [VW-1:0] vy [3];
	logic signed [PW-1:0] pt_x [3];	// pixel, main point, backup point (scaled)
	logic signed [PW-1:0] pt_y [3];
	logic signed [PW-1:0] pix_hi_x, pix_hi_y;	// (pixel+1) scaled
	logic                 on_screen, in_box;

	assign vx[0] = vertex0_x;
	assign vy[0] = vertex0_y;
	assign vx[1] = vertex1_x;
	assign vy[1] = vertex1_y;
	assign vx[2] = vertex2_x;
	assign vy[2] = vertex2_y;

	assign pt_x[0] = PW'({1'b0, pixel_x}) <<< FRACTION_BITS;
	assign pt_y[0] = PW'({1'b0, pixel_y}) <<< FRACTION_BITS;
	assign pt_x[1] = PW'(off_x_q) <<< FRACTION_BITS;
	assign pt_y[1] = PW'(off_y_q) <<< FRACTION_BITS;
	assign pt_x[2] = PW'(bak_x_q) <<< FRACTION_BITS;
	assign pt_y[2] = PW'(bak_y_q) <<< FRACTION_BITS;

	assign pix_hi_x = PW'({1'b0, pixel_x} + (XW + 1)'(1)) <<< FRACTION_BITS;
	assign pix_hi_y = PW'({1'b0, pixel_y} + (XW + 1)'(1)) <<< FRACTION_BITS;

	assign on_screen = (int'(pixel_x) < tpct_pkg::SCREEN_SIZE)
	                && (int'(pixel_y) < tpct_pkg::SCREEN_SIZE);

	// floor(min) <= p < ceil(max)  <=>  min < p+1 and max > p, checked per corner
	always_comb begin
		logic lo_x, hi_x, lo_y, hi_y;
		lo_x = 1'b0;
		hi_x = 1'b0;
		lo_y = 1'b0;
		hi_y = 1'b0;
		for (int k = 0; k < 3; k++) begin
			lo_x = lo_x || (PW'(vx[k]) < pix_hi_x);
			hi_x = hi_x || (PW'(vx[k]) > pt_x[0]);
			lo_y = lo_y || (PW'(vy[k]) < pix_hi_y);
			hi_y = hi_y || (PW'(vy[k]) > pt_y[0]);
		end
		in_box = lo_x && hi_x && lo_y && hi_y;
	end

	// ---------------- side data, s1..s3 ----------------
	logic           ok_s1, ok_s2, ok_s3;
	logic [XW-1:0]  px_s1, px_s2, px_s3, py_s1, py_s2, py_s3;
	logic [CLW-1:0] r_s1, r_s2, r_s3, g_s1, g_s2, g_s3, b_s1, b_s2, b_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_s1 <= on_screen && in_box;
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
			r_s1  <= red;
			g_s1  <= green;
			b_s1  <= blue;
			ok_s2 <= ok_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			r_s2  <= r_s1;
			g_s2  <= g_s1;
			b_s2  <= b_s1;
			ok_s3 <= ok_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			r_s3  <= r_s2;
			g_s3  <= g_s2;
			b_s3  <= b_s2;
		end
	end

	// ---------------- edge evaluators ----------------
	// area sign: edge through corners 1,2 evaluated at corner 0
	tpct_pkg::sign_t area_sgn;
	tpct_pkg::sign_t edge_sgn [3][3];	// [point][edge]

	tpct_edge #(.PW(PW)) u_area (
		.clk (clk),
		.en  (advance),
		.ax  (vx[1]),
		.ay  (vy[1]),
		.bx  (vx[2]),
		.by  (vy[2]),
		.px  (PW'(vx[0])),
		.py  (PW'(vy[0])),
		.sgn (area_sgn)
	);

	// edge k runs from corner k+1 to corner k+2
	for (genvar j = 0; j < 3; j++) begin : g_pt
		for (genvar k = 0; k < 3; k++) begin : g_edge
			tpct_edge #(.PW(PW)) u_edge (
				.clk (clk),
				.en  (advance),
				.ax  (vx[(k + 1) % 3]),
				.ay  (vy[(k + 1) % 3]),
				.bx  (vx[(k + 2) % 3]),
				.by  (vy[(k + 2) % 3]),
				.px  (pt_x[j]),
				.py  (pt_y[j]),
				.sgn (edge_sgn[j][k])
			);
		end
	end

	// ---------------- stage 3 decision ----------------
	logic draw;

	always_comb begin
		logic pix_ok, main_ok, bak_ok, on_edge, sd_pos;
		sd_pos  = area_sgn.pos;
		pix_ok  = 1'b1;
		main_ok = 1'b1;
		bak_ok  = 1'b1;
		for (int k = 0; k < 3; k++) begin
			// pixel on the wrong side of any edge: out
			if (sd_pos ? edge_sgn[0][k].neg : edge_sgn[0][k].pos)
				pix_ok = 1'b0;
			on_edge = !edge_sgn[0][k].pos && !edge_sgn[0][k].neg;
			// on an edge: tie-break point must be strictly inside that edge
			if (on_edge && !(sd_pos ? edge_sgn[1][k].pos : edge_sgn[1][k].neg))
				main_ok = 1'b0;
			if (on_edge && !(sd_pos ? edge_sgn[2][k].pos : edge_sgn[2][k].neg))
				bak_ok = 1'b0;
		end
		draw = ok_s3 && (area_sgn.pos || area_sgn.neg) && pix_ok && (main_ok || bak_ok);
	end

	// ---------------- output register ----------------
	logic [XW-1:0]  out_x_q, out_y_q;
	logic [CLW-1:0] out_r_q, out_g_q, out_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s3 && draw;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_x_q <= px_s3;
			out_y_q <= py_s3;
			out_r_q <= r_s3;
			out_g_q <= g_s3;
			out_b_q <= b_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_red   = out_r_q;
	assign out_green = out_g_q;
	assign out_blue  = out_b_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the triangle pixel coverage test block.
`timescale 1ns / 100ps

module tb;

	localparam int  FRAC_ONE     = 1 << tpct_pkg::FRACTION_BITS;
	localparam int  PHASE_ITEMS  = 356;	// random items per register setting
	localparam int  HOLD_CYCLES  = 200;	// long receiver hold-off
	localparam int  SETTLE       = 8;	// drain margin past the pipeline depth
	localparam int  CYCLE_LIMIT  = 300000;
	localparam int  ERR_SHOWN    = 10;

	// directed rows either carry a typed outcome or defer to the predictor
	typedef enum logic [1:0] {BY_PREDICTOR, KNOWN_DROP, KNOWN_DRAW} verdict_t;

	typedef struct packed {
		logic [2:0][tpct_pkg::VTX_W-1:0] vx;
		logic [2:0][tpct_pkg::VTX_W-1:0] vy;
		logic [tpct_pkg::PIX_W-1:0]      px;
		logic [tpct_pkg::PIX_W-1:0]      py;
		logic [tpct_pkg::COL_W-1:0]      red;
		logic [tpct_pkg::COL_W-1:0]      green;
		logic [tpct_pkg::COL_W-1:0]      blue;
	} tri_item_t;

	typedef struct packed {
		logic [tpct_pkg::PIX_W-1:0] x;
		logic [tpct_pkg::PIX_W-1:0] y;
		logic [tpct_pkg::COL_W-1:0] red;
		logic [tpct_pkg::COL_W-1:0] green;
		logic [tpct_pkg::COL_W-1:0] blue;
	} drawn_pixel_t;

	// main and backup tie-break points, pixel units
	typedef struct packed {
		logic signed [tpct_pkg::OFF_W-1:0] main_x;
		logic signed [tpct_pkg::OFF_W-1:0] main_y;
		logic signed [tpct_pkg::OFF_W-1:0] back_x;
		logic signed [tpct_pkg::OFF_W-1:0] back_y;
	} tie_pts_t;

	typedef struct packed {
		tri_item_t item;
		verdict_t  verdict;
		logic      on_edge_pts;	// needs the collinear tie-point setting
	} stim_row_t;

	// both tie points on the line y = 0
	localparam tie_pts_t EDGE_PTS = '{13'sd5, 13'sd0, 13'sd9, 13'sd0};

	// ------------------------------------------------------------------
	// DUT signals; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              valid = 1'b0;
	logic                              stall;
	logic signed [tpct_pkg::VTX_W-1:0] vertex0_x = '0, vertex0_y = '0;
	logic signed [tpct_pkg::VTX_W-1:0] vertex1_x = '0, vertex1_y = '0;
	logic signed [tpct_pkg::VTX_W-1:0] vertex2_x = '0, vertex2_y = '0;
	logic [tpct_pkg::PIX_W-1:0]        pixel_x = '0, pixel_y = '0;
	logic [tpct_pkg::COL_W-1:0]        red = '0, green = '0, blue = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [tpct_pkg::PIX_W-1:0]        out_x, out_y;
	logic [tpct_pkg::COL_W-1:0]        out_red, out_green, out_blue;
	logic                              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [tpct_pkg::ADDR_W-1:0]       paddr = '0;
	logic [tpct_pkg::DATA_W-1:0]       pwdata = '0;
	logic [tpct_pkg::DATA_W-1:0]       prdata;
	logic                              pready;

	triangle_pixel_coverage_test dut (.*);

	// ------------------------------------------------------------------
	// Scoreboard state
	// ------------------------------------------------------------------
	drawn_pixel_t expected_pixels[$];	// oldest first
	stim_row_t    directed_rows[$];
	tie_pts_t     tie_pts;		// predictor's copy of registers 0..3
	tie_pts_t     phase_pts[5];
	int           errors = 0;
	int           cycle_count = 0;
	bit           calm = 1'b0;		// no idling on either side
	bit           hold_req = 1'b0;
	bit           hold_done = 1'b0;
	drawn_pixel_t got_pixel, want_pixel;

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog. Ends the run as a failure if the stimulus never completes.
	initial begin
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb NOT OK");
		$finish;
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= ERR_SHOWN)
			$display("%s", msg);
	endtask

	// ------------------------------------------------------------------
	// Predictor: integer edge functions, exact sign tests, no division
	// ------------------------------------------------------------------
	function automatic longint side_of(input longint px, input longint py,
			input longint ax, input longint ay, input longint bx, input longint by);
		return (ay - by) * px + (bx - ax) * py + ax * by - bx * ay;
	endfunction

	function automatic int sign_of(input longint v);
		if (v > 0)
			return 1;
		else if (v < 0)
			return -1;
		return 0;
	endfunction

	// Edge k runs through corners k+1 and k+2; result is oriented by the winding sd.
	function automatic int edge_sign(input int k, input longint qx, input longint qy,
			input tri_item_t t, input int sd);
		int     a;
		int     b;
		longint e;
		a = (k + 1) % 3;
		b = (k + 2) % 3;
		e = side_of(qx, qy, longint'($signed(t.vx[a])), longint'($signed(t.vy[a])),
			longint'($signed(t.vx[b])), longint'($signed(t.vy[b])));
		return sign_of(e) * sd;
	endfunction

	// A tie point resolves the pixel when it is strictly inside every edge
	// that the pixel sits on.
	function automatic bit tie_point_wins(input tri_item_t t, input longint qx,
			input longint qy, input logic signed [tpct_pkg::OFF_W-1:0] ox,
			input logic signed [tpct_pkg::OFF_W-1:0] oy, input int sd);
		int k;
		for (k = 0; k < 3; k++)
			if (edge_sign(k, qx, qy, t, sd) == 0 &&
					edge_sign(k, longint'(ox) * FRAC_ONE, longint'(oy) * FRAC_ONE, t, sd) <= 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit pixel_covered(input tri_item_t t, input tie_pts_t p);
		longint px, py, qx, qy, vx, vy;
		longint min_x, max_x, min_y, max_y;
		int     sd;
		int     k;
		px = longint'(t.px);
		py = longint'(t.py);
		if (px >= tpct_pkg::SCREEN_SIZE || py >= tpct_pkg::SCREEN_SIZE)
			return 1'b0;
		min_x = longint'($signed(t.vx[0]));
		max_x = min_x;
		min_y = longint'($signed(t.vy[0]));
		max_y = min_y;
		for (k = 1; k < 3; k++) begin
			vx = longint'($signed(t.vx[k]));
			vy = longint'($signed(t.vy[k]));
			if (vx < min_x) min_x = vx;
			if (vx > max_x) max_x = vx;
			if (vy < min_y) min_y = vy;
			if (vy > max_y) max_y = vy;
		end
		// half-open box [floor(min), ceil(max)) in fixed point
		if (!((px + 1) * FRAC_ONE > min_x && px * FRAC_ONE < max_x))
			return 1'b0;
		if (!((py + 1) * FRAC_ONE > min_y && py * FRAC_ONE < max_y))
			return 1'b0;
		sd = sign_of(side_of(longint'($signed(t.vx[0])), longint'($signed(t.vy[0])),
			longint'($signed(t.vx[1])), longint'($signed(t.vy[1])),
			longint'($signed(t.vx[2])), longint'($signed(t.vy[2]))));
		if (sd == 0)
			return 1'b0;	// zero area
		qx = px * FRAC_ONE;
		qy = py * FRAC_ONE;
		for (k = 0; k < 3; k++)
			if (edge_sign(k, qx, qy, t, sd) < 0)
				return 1'b0;
		return tie_point_wins(t, qx, qy, p.main_x, p.main_y, sd) ||
			tie_point_wins(t, qx, qy, p.back_x, p.back_y, sd);
	endfunction

	// ------------------------------------------------------------------
	// Register port: write, then read back and compare the 13 live bits
	// ------------------------------------------------------------------
	task automatic program_reg(input logic [1:0] idx,
			input logic signed [tpct_pkg::OFF_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(tpct_pkg::DATA_W-tpct_pkg::OFF_W){val[tpct_pkg::OFF_W-1]}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (prdata[tpct_pkg::OFF_W-1:0] !== val)
			flag_error($sformatf("register %0d read back %h, wrote %h",
				idx, prdata[tpct_pkg::OFF_W-1:0], val));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_tie_points(input tie_pts_t p);
		program_reg(tpct_pkg::REG_OFF_X, p.main_x);
		program_reg(tpct_pkg::REG_OFF_Y, p.main_y);
		program_reg(tpct_pkg::REG_BAK_X, p.back_x);
		program_reg(tpct_pkg::REG_BAK_Y, p.back_y);
		tie_pts = p;
	endtask

	// Sender stops offering, waits for every drawn pixel, then lets any
	// dropped item still in the pipe run out.
	task automatic wait_drained();
		valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_item(input tri_item_t t, input verdict_t v);
		bit drawn;
		while (!calm && $urandom_range(99) < 26) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid     <= 1'b1;
		vertex0_x <= t.vx[0];
		vertex0_y <= t.vy[0];
		vertex1_x <= t.vx[1];
		vertex1_y <= t.vy[1];
		vertex2_x <= t.vx[2];
		vertex2_y <= t.vy[2];
		pixel_x   <= t.px;
		pixel_y   <= t.py;
		red       <= t.red;
		green     <= t.green;
		blue      <= t.blue;
		@(posedge clk);
		while (stall !== 1'b0) @(posedge clk);
		// accepted at this edge
		if (v == BY_PREDICTOR)
			drawn = pixel_covered(t, tie_pts);
		else
			drawn = (v == KNOWN_DRAW);
		if (drawn)
			expected_pixels.push_back('{t.px, t.py, t.red, t.green, t.blue});
	endtask

	task automatic add_row(input verdict_t v, input bit edge_pts,
			input int x0, input int y0, input int x1, input int y1, input int x2, input int y2,
			input int px, input int py, input int r, input int g, input int b);
		stim_row_t row;
		row.item.vx[0]   = tpct_pkg::VTX_W'(x0);
		row.item.vy[0]   = tpct_pkg::VTX_W'(y0);
		row.item.vx[1]   = tpct_pkg::VTX_W'(x1);
		row.item.vy[1]   = tpct_pkg::VTX_W'(y1);
		row.item.vx[2]   = tpct_pkg::VTX_W'(x2);
		row.item.vy[2]   = tpct_pkg::VTX_W'(y2);
		row.item.px      = tpct_pkg::PIX_W'(px);
		row.item.py      = tpct_pkg::PIX_W'(py);
		row.item.red     = tpct_pkg::COL_W'(r);
		row.item.green   = tpct_pkg::COL_W'(g);
		row.item.blue    = tpct_pkg::COL_W'(b);
		row.verdict      = v;
		row.on_edge_pts  = edge_pts;
		directed_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall, plus one long hold-off on request so the
	// pipeline fills and back-pressures the input.
	// ------------------------------------------------------------------
	initial begin
		int hold_cnt;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
				hold_done = 1'b1;
			end
			out_stall <= !calm && ($urandom_range(99) < 26);
		end
	end

	// Checker: every accepted output is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got_pixel = '{out_x, out_y, out_red, out_green, out_blue};
			if (expected_pixels.size() == 0) begin
				flag_error($sformatf("unexpected pixel x=%0d y=%0d rgb=%h/%h/%h",
					out_x, out_y, out_red, out_green, out_blue));
			end else begin
				want_pixel = expected_pixels.pop_front();
				if (got_pixel.x !== want_pixel.x || got_pixel.y !== want_pixel.y ||
						got_pixel.red !== want_pixel.red ||
						got_pixel.green !== want_pixel.green ||
						got_pixel.blue !== want_pixel.blue)
					flag_error($sformatf(
						"pixel mismatch: got x=%0d y=%0d rgb=%h/%h/%h, want x=%0d y=%0d rgb=%h/%h/%h",
						got_pixel.x, got_pixel.y, got_pixel.red, got_pixel.green, got_pixel.blue,
						want_pixel.x, want_pixel.y, want_pixel.red, want_pixel.green,
						want_pixel.blue));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		tri_item_t it;
		stim_row_t row;
		int        ph, n, k, mode, span, cx, cy, pick;
		bit        edge_pts_loaded;

		tie_pts = '{tpct_pkg::OFF_X_RST, tpct_pkg::OFF_Y_RST,
			tpct_pkg::BAK_X_RST, tpct_pkg::BAK_Y_RST};
		edge_pts_loaded = 1'b0;

		// Register settings for the random phases: both extreme corners,
		// all zero (main and backup coincide), the reset values, and one random.
		phase_pts[0] = '{-13'sd4096, -13'sd4096, 13'sd4095, 13'sd4095};
		phase_pts[1] = '{13'sd4095, 13'sd4095, -13'sd4096, -13'sd4096};
		phase_pts[2] = '{13'sd0, 13'sd0, 13'sd0, 13'sd0};
		phase_pts[3] = '{tpct_pkg::OFF_X_RST, tpct_pkg::OFF_Y_RST,
			tpct_pkg::BAK_X_RST, tpct_pkg::BAK_Y_RST};
		phase_pts[4] = {13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom)};

		// Directed table. Vertices are in 1/16 pixel units.
		//          verdict       edge  v0           v1             v2             pixel       colour
		add_row(KNOWN_DROP,   0, 160, 160,   160, 160,     160, 160,     10, 10,     1, 2, 3);
		add_row(KNOWN_DROP,   0, 0, 0,       320, 320,     640, 640,     10, 10,     4, 5, 6);
		add_row(KNOWN_DRAW,   0, 0, 0,       1600, 0,      0, 1600,      10, 10,     255, 0, 255);
		add_row(KNOWN_DRAW,   0, 0, 0,       0, 1600,      1600, 0,      20, 30,     0, 255, 0);
		add_row(KNOWN_DROP,   0, 0, 0,       1600, 0,      0, 1600,      200, 5,     7, 8, 9);
		add_row(KNOWN_DROP,   0, 0, 0,       1600, 0,      0, 1600,      90, 90,     10, 11, 12);
		add_row(BY_PREDICTOR, 0, -32768, -32768, 32767, -32768, 32767, 32767, 1023, 0, 255, 255, 255);
		add_row(BY_PREDICTOR, 0, 32767, 32767, -32768, 32767, -32768, -32768, 0, 1023, 128, 64, 32);
		add_row(BY_PREDICTOR, 0, -32768, -32768, 32767, -32768, -32768, 32767, 1023, 1023,
			85, 170, 85);
		add_row(KNOWN_DRAW,   0, 16000, 16000, 17000, 16000,  16000, 17000, 1023, 1023, 0, 0, 0);
		add_row(KNOWN_DRAW,   0, -160, -160, 320, -160,    -160, 320,    0, 0,       170, 85, 170);
		// pixel on a corner, then on each edge of a right triangle
		add_row(BY_PREDICTOR, 0, 0, 0,       160, 0,       0, 160,       0, 0,       20, 21, 22);
		add_row(BY_PREDICTOR, 0, 0, 0,       320, 0,       0, 320,       0, 3,       23, 24, 25);
		add_row(BY_PREDICTOR, 0, 0, 0,       320, 0,       0, 320,       3, 0,       26, 27, 28);
		add_row(BY_PREDICTOR, 0, 0, 0,       320, 0,       0, 320,       10, 10,     29, 30, 31);
		add_row(BY_PREDICTOR, 0, 8, 8,       329, 5,       3, 331,       5, 5,       32, 33, 34);
		// box edges: pixel left of floor(min), then pixel right at floor(min)
		add_row(KNOWN_DROP,   0, 16, 16,     1600, 16,     16, 1600,     0, 5,       35, 36, 37);
		add_row(BY_PREDICTOR, 0, 17, 17,     1600, 17,     17, 1600,     1, 1,       38, 39, 40);
		// both tie points on the bottom edge: a pixel on that edge is never drawn
		add_row(KNOWN_DROP,   1, 0, 0,       320, 0,       0, 320,       3, 0,       41, 42, 43);
		add_row(BY_PREDICTOR, 1, 0, 0,       320, 0,       0, 320,       0, 3,       44, 45, 46);
		add_row(KNOWN_DRAW,   1, 0, 0,       320, 0,       0, 320,       5, 5,       47, 48, 49);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs first, with the reset register values until the edge-point rows
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.on_edge_pts && !edge_pts_loaded) begin
				wait_drained();
				write_tie_points(EDGE_PTS);
				edge_pts_loaded = 1'b1;
			end
			send_item(row.item, row.verdict);
		end

		// Random part. Most triangles sit around the pixel, many with corners on
		// the pixel grid so that pixels land on edges and corners; the rest are
		// unconstrained, degenerate, or pinned to the coordinate extremes.
		for (ph = 0; ph < 5; ph++) begin
			wait_drained();
			write_tie_points(phase_pts[ph]);
			calm = (ph == 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 60)
					hold_req = 1'b1;	// receiver holds off while items keep coming
				if (ph == 3 && n == 150)
					wait_drained();		// sender pauses until all pixels are out
				if ($urandom_range(9) == 0)
					it.px = $urandom_range(1) ? 10'd1023 : 10'd0;
				else
					it.px = tpct_pkg::PIX_W'($urandom_range(1023));
				if ($urandom_range(9) == 0)
					it.py = $urandom_range(1) ? 10'd1023 : 10'd0;
				else
					it.py = tpct_pkg::PIX_W'($urandom_range(1023));
				it.red   = tpct_pkg::COL_W'($urandom_range(255));
				it.green = tpct_pkg::COL_W'($urandom_range(255));
				it.blue  = tpct_pkg::COL_W'($urandom_range(255));
				cx   = int'(it.px) * FRAC_ONE;
				cy   = int'(it.py) * FRAC_ONE;
				mode = $urandom_range(99);
				span = $urandom_range(8, 1);
				for (k = 0; k < 3; k++) begin
					if (mode < 40 || (mode >= 80 && mode < 90)) begin
						it.vx[k] = tpct_pkg::VTX_W'(cx +
							FRAC_ONE * (int'($urandom_range(2 * span)) - span));
						it.vy[k] = tpct_pkg::VTX_W'(cy +
							FRAC_ONE * (int'($urandom_range(2 * span)) - span));
					end else if (mode < 70) begin
						it.vx[k] = tpct_pkg::VTX_W'(cx +
							int'($urandom_range(2 * FRAC_ONE * span)) - FRAC_ONE * span);
						it.vy[k] = tpct_pkg::VTX_W'(cy +
							int'($urandom_range(2 * FRAC_ONE * span)) - FRAC_ONE * span);
					end else if (mode < 80) begin
						it.vx[k] = tpct_pkg::VTX_W'($urandom);
						it.vy[k] = tpct_pkg::VTX_W'($urandom);
					end else begin
						pick = $urandom_range(3);
						it.vx[k] = tpct_pkg::VTX_W'((pick == 0) ? -32768 : (pick == 1) ? 32767 :
							cx + FRAC_ONE * (int'($urandom_range(2 * span)) - span));
						pick = $urandom_range(3);
						it.vy[k] = tpct_pkg::VTX_W'((pick == 0) ? -32768 : (pick == 1) ? 32767 :
							cy + FRAC_ONE * (int'($urandom_range(2 * span)) - span));
					end
				end
				// degenerate: repeated corner, or third corner on the first edge's line
				if (mode >= 80 && mode < 90) begin
					if ($urandom_range(1)) begin
						it.vx[2] = it.vx[1];
						it.vy[2] = it.vy[1];
					end else begin
						it.vx[2] = tpct_pkg::VTX_W'(2 * int'($signed(it.vx[1])) -
							int'($signed(it.vx[0])));
						it.vy[2] = tpct_pkg::VTX_W'(2 * int'($signed(it.vy[1])) -
							int'($signed(it.vy[0])));
					end
				end
				send_item(it, BY_PREDICTOR);
			end
		end

		calm = 1'b1;
		wait_drained();
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tpct_pkg.sv
rtl/tpct_edge.sv
rtl/triangle_pixel_coverage_test.sv
tb/sv/tb.sv
